### src/websocket_frame_deframer_macros.svh
// Assertion macros for the WebSocket frame deframer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// General form with an explicit clock and reset.
`define WSFD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Common form on the block clock and reset.
`define WSFD_ASSERT(lbl, prop, msg) \
   `WSFD_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define WSFD_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define WSFD_ASSERT(lbl, prop, msg)
`endif

`endif

### src/wsfd_pkg.sv
// Package for the WebSocket frame deframer: parser phases, result struct, constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsfd_pkg;

   // Parser phases of the frame header and payload.
   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   // One result transfer.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        fin_flag;
      logic [3:0]  frame_opcode;
      logic        was_masked;
      logic [62:0] frame_length;
      logic        oversize;
      logic        last;
   } result_type;

   localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;
   localparam logic [2:0]  EXT16_BYTES    = 3'd2;
   localparam logic [2:0]  EXT64_WRAP     = 3'd0;
   localparam logic [2:0]  KEY_LAST_BYTE  = 3'd3;
   localparam logic [31:0] MAX_LEN_RESET  = 32'd4096;

   // Register index decoded from the configuration address.
   localparam logic CSR_IDX_MAX_LEN = 1'b0;

endpackage

`default_nettype wire

### src/websocket_frame_deframer.sv
// WebSocket frame deframer (RFC 6455 base framing), one byte of frame stream per cycle.
// A byte enters an input register; the parser decodes FIN, opcode, mask flag, the 7-bit,
// 16-bit or 64-bit length and the masking key, and each payload byte leaves through the
// result register unmasked, with the frame header, an oversize flag (length above
// max_payload_len at CSR byte address 0) and a last marker. A frame of length zero gives one
// result with data_valid low; other header bytes give no result. The block takes one byte
// every cycle while req_stall is low; a payload byte passes the input register, then the
// result register. rsp_stall reaches req_stall combinationally only when the result
// register is full and the byte in the input register has a result to deliver.
// Depends on wsfd_pkg, wsfd_csr, wsfd_parse and wsfd_outreg.
`default_nettype none

module websocket_frame_deframer
   import wsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input byte stream.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   // Result stream.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_data_valid,
   output logic             rsp_fin_flag,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_was_masked,
   output logic [62:0]      rsp_frame_length,
   output logic             rsp_oversize,
   output logic             rsp_last,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic       [31:0] max_len;
   logic              out_ready;
   logic              res_load;
   result_type        res;
   result_type        rsp_res;

   wsfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   wsfd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .max_len     (max_len),
      .out_ready   (out_ready),
      .res_load    (res_load),
      .res         (res)
   );

   wsfd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res_in    (res),
      .rsp_stall (rsp_stall),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   // Result fields onto their ports.
   assign rsp_data_byte    = rsp_res.data_byte;
   assign rsp_data_valid   = rsp_res.data_valid;
   assign rsp_fin_flag     = rsp_res.fin_flag;
   assign rsp_frame_opcode = rsp_res.frame_opcode;
   assign rsp_was_masked   = rsp_res.was_masked;
   assign rsp_frame_length = rsp_res.frame_length;
   assign rsp_oversize     = rsp_res.oversize;
   assign rsp_last         = rsp_res.last;

endmodule

`default_nettype wire

### src/wsfd_csr.sv
// Configuration register block of the WebSocket frame deframer (APB-style port).
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_csr
   import wsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [31:0]      max_len
);

   logic [31:0] max_len_ff;
   logic [31:0] max_len_in;
   logic        wr_en;
   logic        reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // A write transfer to the limit register updates it.
   always_comb begin
      max_len_in = max_len_ff;
      if (wr_en && (reg_idx == CSR_IDX_MAX_LEN)) begin
         max_len_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Read back; addresses past the register list read as zero.
   always_comb begin
      csr_prdata = 32'd0;
      if (reg_idx == CSR_IDX_MAX_LEN) begin
         csr_prdata = max_len_ff;
      end
   end

   assign max_len = max_len_ff;

endmodule

`default_nettype wire

### src/wsfd_parse.sv
// Input register and header/payload parser of the WebSocket frame deframer.
// Depends on wsfd_pkg and websocket_frame_deframer_macros.svh.
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsfd_parse
   import wsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_in_byte,
   output logic             req_stall,
   input  wire logic [31:0] max_len,
   input  wire logic        out_ready,
   output logic             res_load,
   output result_type       res
);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   // Frame state.
   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [62:0] length_ff, length_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [62:0] remain_ff, remain_in;
   logic [1:0]  idx_ff, idx_in;

   logic        advance;
   logic        in_ready;
   logic        emit;
   logic [7:0]  data_out;
   logic        data_vld;
   logic        last_out;
   logic [7:0]  key_byte;
   logic [6:0]  code;
   logic        len_done;
   logic        hdr_done;
   logic [62:0] hdr_len;
   logic        hdr_mask;

   // The byte in the input register moves on unless its result finds the output full.
   assign advance   = in_valid_ff && (!emit || out_ready);
   assign in_ready  = !in_valid_ff || advance;
   assign req_stall = !in_ready;
   assign res_load  = advance && emit;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // Key byte for the current payload position; the first key byte on the wire comes first.
   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign code = in_byte_ff[6:0];

   // Next state and result for the byte in the input register.
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      length_in = length_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      remain_in = remain_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      data_out  = 8'd0;
      data_vld  = 1'b0;
      last_out  = 1'b0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      hdr_len   = length_ff;
      hdr_mask  = mask_ff;

      if (in_valid_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = in_byte_ff[7];
               opcode_in = in_byte_ff[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in   = in_byte_ff[7];
               hdr_mask  = in_byte_ff[7];
               cnt_in    = 3'd0;
               length_in = 63'd0;
               if (code == LEN_CODE_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (code == LEN_CODE_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  length_in = {56'd0, code};
                  hdr_len   = {56'd0, code};
                  len_done  = 1'b1;
               end
            end
            PH_EXT16, PH_EXT64: begin
               length_in = {length_ff[54:0], in_byte_ff};
               hdr_len   = {length_ff[54:0], in_byte_ff};
               cnt_in    = cnt_ff + 3'd1;
               if (((phase_ff == PH_EXT16) && (cnt_in == EXT16_BYTES)) ||
                   ((phase_ff == PH_EXT64) && (cnt_in == EXT64_WRAP))) begin
                  len_done = 1'b1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], in_byte_ff};
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == KEY_LAST_BYTE) begin
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               emit      = 1'b1;
               data_vld  = 1'b1;
               data_out  = mask_ff ? (in_byte_ff ^ key_byte) : in_byte_ff;
               idx_in    = idx_ff + 2'd1;
               remain_in = remain_ff - 63'd1;
               if (remain_ff == 63'd1) begin
                  last_out = 1'b1;
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // Length complete: either fetch the key or finish the header.
         if (len_done) begin
            cnt_in = 3'd0;
            if (hdr_mask) begin
               key_in   = 32'd0;
               phase_in = PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end

         // Header complete: an empty frame gives one header-only result.
         if (hdr_done) begin
            cnt_in    = 3'd0;
            idx_in    = 2'd0;
            remain_in = hdr_len;
            if (hdr_len == 63'd0) begin
               emit     = 1'b1;
               last_out = 1'b1;
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b1;
         opcode_ff <= 4'd1;
         mask_ff   <= 1'b0;
         length_ff <= 63'd0;
         cnt_ff    <= 3'd0;
         key_ff    <= 32'd0;
         remain_ff <= 63'd0;
         idx_ff    <= 2'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
      end
   end

   // Result fields; the header fields are those after this byte is taken.
   always_comb begin
      res.data_byte    = data_out;
      res.data_valid   = data_vld;
      res.fin_flag     = fin_in;
      res.frame_opcode = opcode_in;
      res.was_masked   = mask_in;
      res.frame_length = length_in;
      res.oversize     = (length_in[62:32] != 31'd0) || (length_in[31:0] > max_len);
      res.last         = last_out;
   end

   // A frame in the payload phase always has bytes left to deliver.
   `WSFD_ASSERT(a_remain_nonzero, (phase_ff == PH_DATA) |-> (remain_ff != 63'd0),
                "payload phase entered with no bytes remaining")
   // A result outside the payload phase is the header-only result of an empty frame.
   `WSFD_ASSERT(a_hdr_only, (res_load && (phase_ff != PH_DATA)) |->
                (!res.data_valid && res.last && (res.frame_length == 63'd0)),
                "header-only result is malformed")
   // A first header byte always leads to the second one.
   `WSFD_ASSERT(a_hdr_seq, (advance && (phase_ff == PH_HDR0)) |=> (phase_ff == PH_HDR1),
                "first header byte did not lead to the second")
   // The last payload byte returns the parser to the start of a frame.
   `WSFD_ASSERT(a_last_return, (res_load && res.last) |=> (phase_ff == PH_HDR0),
                "parser did not return to frame start after the last result")

endmodule

`default_nettype wire

### src/wsfd_outreg.sv
// Result register of the WebSocket frame deframer.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_outreg
   import wsfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_load,
   input  wire result_type res_in,
   input  wire logic       rsp_stall,
   output logic            out_ready,
   output logic            rsp_valid,
   output result_type      rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in_d;

   // The register can take a new result when empty or when its content transfers now.
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in_d = res_ff;
      if (out_ready) begin
         valid_in = res_load;
         if (res_load) begin
            res_in_d = res_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in_d;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: a directed frame table, then random
// frames over several max_payload_len settings, each result checked against a predictor.
// Depends on wsfd_pkg and the deframer RTL only.

module tb_top;
   import wsfd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BYTES  = 125;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PERCENT = 11;
   localparam logic [2:0] MAX_LEN_ADDR = {CSR_IDX_MAX_LEN, 2'b00};

   typedef struct {
      logic [7:0] in_byte;
      bit         typed;
      result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_byte;
   logic        rsp_data_valid;
   logic        rsp_fin_flag;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_was_masked;
   logic [62:0] rsp_frame_length;
   logic        rsp_oversize;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: a private copy of the parser and of the length limit.
   phase_type   parse_phase;
   logic        hdr_fin;
   logic [3:0]  hdr_opcode;
   logic        hdr_masked;
   logic [63:0] hdr_length;
   logic [2:0]  field_count;
   logic [31:0] key_word;
   logic [63:0] data_count;
   logic [31:0] max_len_cfg;

   result_type   pending_results[$];
   stim_row_type directed_rows[$];
   int           error_count = 0;
   int           phase_bytes = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;
   bit           hold_request = 1'b0;

   websocket_frame_deframer DUT (.*);

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic result_type res_of(input logic [7:0] data, input logic dv,
                                         input logic fin, input logic [3:0] opcode,
                                         input logic masked, input logic [62:0] len,
                                         input logic ovs, input logic lst);
      result_type r;
      r.data_byte    = data;
      r.data_valid   = dv;
      r.fin_flag     = fin;
      r.frame_opcode = opcode;
      r.was_masked   = masked;
      r.frame_length = len;
      r.oversize     = ovs;
      r.last         = lst;
      return r;
   endfunction

   // Advance the parser copy by one byte and form the result it causes, if any.
   task automatic deframe_byte(input logic [7:0] b, output bit produced, output result_type res);
      bit         len_done;
      bit         hdr_done;
      logic [7:0] key_byte;
      logic [7:0] out_data;
      logic       out_dv;
      logic       out_last;
      produced = 1'b0;
      len_done = 1'b0;
      hdr_done = 1'b0;
      out_data = '0;
      out_dv   = 1'b0;
      out_last = 1'b0;
      res      = '0;
      case (parse_phase)
         PH_HDR0: begin
            hdr_fin     = b[7];
            hdr_opcode  = b[3:0];
            parse_phase = PH_HDR1;
         end
         PH_HDR1: begin
            hdr_masked  = b[7];
            field_count = '0;
            hdr_length  = '0;
            if (b[6:0] == LEN_CODE_EXT16) begin
               parse_phase = PH_EXT16;
            end else if (b[6:0] == LEN_CODE_EXT64) begin
               parse_phase = PH_EXT64;
            end else begin
               hdr_length = 64'(b[6:0]);
               len_done   = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            // Big-endian shift; the reserved top bit of a 64-bit length falls away.
            hdr_length  = {1'b0, hdr_length[54:0], b};
            field_count = field_count + 3'd1;
            len_done = (parse_phase == PH_EXT16 && field_count == EXT16_BYTES) ||
                       (parse_phase == PH_EXT64 && field_count == EXT64_WRAP);
         end
         PH_KEY: begin
            key_word    = {key_word[23:0], b};
            field_count = field_count + 3'd1;
            hdr_done    = field_count > KEY_LAST_BYTE;
         end
         PH_DATA: begin
            // The first key byte on the wire masks payload bytes 0, 4, 8 and so on.
            key_byte   = hdr_masked ? key_word[(3 - data_count[1:0]) * 8 +: 8] : 8'h00;
            data_count = data_count + 64'd1;
            produced   = 1'b1;
            out_data   = b ^ key_byte;
            out_dv     = 1'b1;
            out_last   = data_count >= hdr_length;
            if (out_last) begin
               parse_phase = PH_HDR0;
            end
         end
         default: begin
            parse_phase = PH_HDR0;
         end
      endcase
      if (len_done) begin
         field_count = '0;
         if (hdr_masked) begin
            key_word    = '0;
            parse_phase = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end
      // A complete header of a zero-length frame gives one header-only result.
      if (hdr_done) begin
         field_count = '0;
         data_count  = '0;
         if (hdr_length == 64'd0) begin
            produced    = 1'b1;
            out_last    = 1'b1;
            parse_phase = PH_HDR0;
         end else begin
            parse_phase = PH_DATA;
         end
      end
      if (produced) begin
         res = res_of(out_data, out_dv, hdr_fin, hdr_opcode, hdr_masked, hdr_length[62:0],
                      hdr_length > {32'd0, max_len_cfg}, out_last);
      end
   endtask

   // Offer one byte, with random idle cycles first, and hold it until the transfer.
   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic push_byte(input logic [7:0] b);
      bit         produced;
      result_type res;
      send_byte(b);
      deframe_byte(b, produced, res);
      if (produced) begin
         pending_results.push_back(res);
      end
      phase_bytes++;
   endtask

   task automatic add_row(input logic [7:0] b);
      directed_rows.push_back('{in_byte: b, typed: 1'b0, want: '0});
   endtask

   task automatic add_want(input logic [7:0] b, input result_type w);
      directed_rows.push_back('{in_byte: b, typed: 1'b1, want: w});
   endtask

   // One register access: setup cycle, access cycle, then a cycle with the port released.
   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_max_len(input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, MAX_LEN_ADDR, value, rd);
      max_len_cfg = value;
      csr_access(1'b0, MAX_LEN_ADDR, '0, rd);
      if (rd !== value) begin
         report_mismatch("max_payload_len readback", rd, value);
      end
   endtask

   // Let every expected result arrive, then cover the header bytes still in flight.
   task automatic wait_for_results();
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One well-formed frame with random header bits, key and payload.
   task automatic send_random_frame();
      logic [63:0] len;
      logic [6:0]  code;
      logic        masked;
      int          pick;
      int          i;
      logic [63:0] n;
      masked = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      if (pick < 12) begin
         len  = '0;
         code = '0;
      end else if (pick < 60) begin
         len  = 64'($urandom_range(1, 16));
         code = len[6:0];
      end else if (pick < 66) begin
         len  = 64'($urandom_range(100, 125));
         code = len[6:0];
      end else if (pick < 83) begin
         // Mostly non-minimal 16-bit lengths, some around the 7-bit boundary.
         len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(120, 135))
                                            : 64'($urandom_range(0, 20));
         code = LEN_CODE_EXT16;
      end else begin
         len  = 64'($urandom_range(0, 20));
         code = LEN_CODE_EXT64;
      end
      push_byte(8'($urandom));
      push_byte({masked, code});
      if (code == LEN_CODE_EXT16) begin
         push_byte(len[15:8]);
         push_byte(len[7:0]);
      end else if (code == LEN_CODE_EXT64) begin
         // The reserved top bit is set at random; the parser drops it.
         len[63] = 1'($urandom_range(0, 1));
         for (i = 7; i >= 0; i--) begin
            push_byte(len[8 * i +: 8]);
         end
      end
      if (masked) begin
         for (i = 0; i < 4; i++) begin
            push_byte(8'($urandom));
         end
      end
      for (n = 0; n < {1'b0, len[62:0]}; n++) begin
         push_byte(8'($urandom));
      end
   endtask

   // Result side: check each transfer and choose the stall for the next cycle.
   initial begin
      result_type got;
      result_type want;
      int         hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.data_byte    = rsp_data_byte;
            got.data_valid   = rsp_data_valid;
            got.fin_flag     = rsp_fin_flag;
            got.frame_opcode = rsp_frame_opcode;
            got.was_masked   = rsp_was_masked;
            got.frame_length = rsp_frame_length;
            got.oversize     = rsp_oversize;
            got.last         = rsp_last;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected", got.data_byte, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.data_byte !== want.data_byte)
                  report_mismatch("data_byte", got.data_byte, want.data_byte);
               if (got.data_valid !== want.data_valid)
                  report_mismatch("data_valid", got.data_valid, want.data_valid);
               if (got.fin_flag !== want.fin_flag)
                  report_mismatch("fin_flag", got.fin_flag, want.fin_flag);
               if (got.frame_opcode !== want.frame_opcode)
                  report_mismatch("frame_opcode", got.frame_opcode, want.frame_opcode);
               if (got.was_masked !== want.was_masked)
                  report_mismatch("was_masked", got.was_masked, want.was_masked);
               if (got.frame_length !== want.frame_length)
                  report_mismatch("frame_length", got.frame_length, want.frame_length);
               if (got.oversize !== want.oversize)
                  report_mismatch("oversize", got.oversize, want.oversize);
               if (got.last !== want.last)
                  report_mismatch("last", got.last, want.last);
            end
         end
         // A long hold-off on request lets the block fill up and stall its input.
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Stimulus and sequencing of the run.
   initial begin
      logic [31:0] rd;
      bit          produced;
      result_type  res;
      bit          hold_done;
      logic [63:0] len;
      logic        masked;
      int          p;
      int          i;
      hold_done   = 1'b0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      parse_phase = PH_HDR0;
      hdr_fin     = 1'b1;
      hdr_opcode  = 4'd1;
      hdr_masked  = 1'b0;
      hdr_length  = '0;
      field_count = '0;
      key_word    = '0;
      data_count  = '0;
      max_len_cfg = MAX_LEN_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b0, MAX_LEN_ADDR, '0, rd);
      if (rd !== MAX_LEN_RESET) begin
         report_mismatch("max_payload_len after reset", rd, MAX_LEN_RESET);
      end

      // Zero-length frame right after reset.
      add_row(8'h81);
      add_want(8'h00, res_of(8'h00, 1'b0, 1'b1, 4'h1, 1'b0, '0, 1'b0, 1'b1));
      // Zero-length frame through a 16-bit length, FIN clear and top opcode.
      add_row(8'h0F);
      add_row(8'h7E);
      add_row(8'h00);
      add_want(8'h00, res_of(8'h00, 1'b0, 1'b0, 4'hF, 1'b0, '0, 1'b0, 1'b1));
      // Masked one-byte frame; the first key byte masks payload byte 0.
      add_row(8'hF0);
      add_row(8'h81);
      add_row(8'h11);
      add_row(8'h22);
      add_row(8'h33);
      add_row(8'h44);
      add_want(8'h55, res_of(8'h44, 1'b1, 1'b1, 4'h0, 1'b1, 63'd1, 1'b0, 1'b1));
      // Non-minimal 64-bit length with the reserved top bit set.
      add_row(8'h89);
      add_row(8'h7F);
      add_row(8'h80);
      for (i = 0; i < 6; i++) begin
         add_row(8'h00);
      end
      add_row(8'h01);
      add_want(8'hC3, res_of(8'hC3, 1'b1, 1'b1, 4'h9, 1'b0, 63'd1, 1'b0, 1'b1));

      foreach (directed_rows[r]) begin
         send_byte(directed_rows[r].in_byte);
         deframe_byte(directed_rows[r].in_byte, produced, res);
         if (directed_rows[r].typed) begin
            pending_results.push_back(directed_rows[r].want);
         end else if (produced) begin
            pending_results.push_back(res);
         end
      end
      req_valid <= 1'b0;
      wait_for_results();

      // Random frames under a sequence of length limits, the extremes among them.
      for (p = 0; p < 5; p++) begin
         case (p)
            1: set_max_len(32'd0);
            2: set_max_len(32'hFFFF_FFFF);
            3: set_max_len(32'($urandom_range(0, 40)));
            4: set_max_len(32'($urandom_range(0, 200)));
            default: ;
         endcase
         quiet       = (p == 1);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            if (p == 2 && !hold_done && phase_bytes > 50) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
            send_random_frame();
         end
         if (p < 4) begin
            req_valid <= 1'b0;
            wait_for_results();
         end
      end

      // A last frame with a huge 64-bit length, left open after a few payload bytes.
      masked = 1'($urandom_range(0, 1));
      len    = {$urandom, $urandom};
      len[62] = 1'b1;
      push_byte(8'($urandom));
      push_byte({masked, LEN_CODE_EXT64});
      for (i = 7; i >= 0; i--) begin
         push_byte(len[8 * i +: 8]);
      end
      if (masked) begin
         for (i = 0; i < 4; i++) begin
            push_byte(8'($urandom));
         end
      end
      for (i = 0; i < 8; i++) begin
         push_byte(8'($urandom));
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
